// ----- rtl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, register indexes and helpers for sensor trim compensation.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_C  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY    = 3'd4;

    localparam int DIV_STEPS = 32;

    localparam logic [31:0] P_OFFSET   = 32'd64000;
    localparam logic [31:0] P_BASE     = 32'd1048576;
    localparam logic [31:0] P_SCALE    = 32'd3125;
    localparam logic [31:0] P_HALF     = 32'd32768;
    localparam logic [31:0] H_OFFSET   = 32'd76800;
    localparam logic [31:0] H_MAX      = 32'd419430400;
    localparam logic [31:0] H_BIAS     = 32'd2097152;
    localparam logic [31:0] H_ROUND_A  = 32'd16384;
    localparam logic [31:0] H_ROUND_B  = 32'd8192;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_pascal;
        logic [16:0]        humidity_fixed;
    } out_item_t;

    typedef struct packed {
        logic [47:0] temperature;
        logic [47:0] pressure_a;
        logic [47:0] pressure_b;
        logic [47:0] pressure_c;
        logic [63:0] humidity;
    } trim_t;

    // fields that ride along the divider pipeline
    typedef struct packed {
        logic [31:0] temp;
        logic [16:0] hum;
        logic        halve;   // numerator was not doubled, double the quotient
        logic        zero;    // divisor was zero
    } side_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        asr = $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] v);
        sx12 = {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        sx8 = {{24{v[7]}}, v};
    endfunction

endpackage

// ----- rtl/stc_front.sv -----
// ----------------------------------------------------------------------------
// stc_front
// Input side: accepts sample items into a two-entry queue for the datapath.
// ----------------------------------------------------------------------------
module stc_front
    import stc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     head_valid,
    output in_item_t head_data,
    input  logic     pop
);

    in_item_t    ent_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        do_pop;

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = ent_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ----- rtl/stc_div.sv -----
// ----------------------------------------------------------------------------
// stc_div
// Pipelined 32/32 unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module stc_div
    import stc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_vld,
    input  logic [31:0] num,
    input  logic [31:0] den,
    input  side_t       in_side,
    output logic        out_vld,
    output logic [31:0] quo,
    output side_t       out_side
);

    logic [63:0] acc_reg  [DIV_STEPS];
    logic [31:0] den_reg  [DIV_STEPS];
    side_t       side_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    logic [63:0] acc_in  [DIV_STEPS];
    logic [31:0] den_in  [DIV_STEPS];
    logic [63:0] acc_nx  [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [32:0] r33;
            logic [32:0] diff;
            if (k == 0)
            begin : g_first
                assign acc_in[k] = {32'd0, num};
                assign den_in[k] = den;
            end
            else
            begin : g_rest
                assign acc_in[k] = acc_reg[k-1];
                assign den_in[k] = den_reg[k-1];
            end
            assign r33  = {acc_in[k][63:32], acc_in[k][31]};
            assign diff = r33 - {1'b0, den_in[k]};
            assign acc_nx[k] = !diff[32] ? {diff[31:0], acc_in[k][30:0], 1'b1}
                                         : {r33[31:0], acc_in[k][30:0], 1'b0};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    acc_reg[k] <= acc_nx[k];
                    den_reg[k] <= den_in[k];
                    side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_vld};
    end

    assign out_vld  = vld_reg[DIV_STEPS-1];
    assign quo      = acc_reg[DIV_STEPS-1][31:0];
    assign out_side = side_reg[DIV_STEPS-1];

endmodule

// ----- rtl/stc_back.sv -----
// ----------------------------------------------------------------------------
// stc_back
// Compensation datapath: temperature, pressure and humidity pipeline.
// ----------------------------------------------------------------------------
module stc_back
    import stc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  trim_t     trim,
    input  logic      head_valid,
    input  in_item_t  head_data,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic adv;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'd0, trim.temperature[15:0]};
    assign t2 = sx16(trim.temperature[31:16]);
    assign t3 = sx16(trim.temperature[47:32]);
    assign p1 = {16'd0, trim.pressure_a[15:0]};
    assign p2 = sx16(trim.pressure_a[31:16]);
    assign p3 = sx16(trim.pressure_a[47:32]);
    assign p4 = sx16(trim.pressure_b[15:0]);
    assign p5 = sx16(trim.pressure_b[31:16]);
    assign p6 = sx16(trim.pressure_b[47:32]);
    assign p7 = sx16(trim.pressure_c[15:0]);
    assign p8 = sx16(trim.pressure_c[31:16]);
    assign p9 = sx16(trim.pressure_c[47:32]);
    assign h1 = {24'd0, trim.humidity[7:0]};
    assign h2 = sx16(trim.humidity[23:8]);
    assign h3 = {24'd0, trim.humidity[31:24]};
    assign h4 = sx12(trim.humidity[43:32]);
    assign h5 = sx12(trim.humidity[55:44]);
    assign h6 = sx8(trim.humidity[63:56]);

    out_item_t out_reg;
    logic      out_vld_reg;

    assign adv       = !(out_vld_reg && out_stall);
    assign pop       = adv;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // front stages valid chain
    logic [12:0] vld_reg;

    logic [31:0] at, ap_in, ah_in;
    assign at    = {12'd0, head_data.raw_temperature};
    assign ap_in = {12'd0, head_data.raw_pressure};
    assign ah_in = {16'd0, head_data.raw_humidity};

    logic [31:0] s1_a1_reg, s1_d_reg, ap_reg [1:8], ah_reg [1:6];
    logic [31:0] s2_m1_reg, s2_dd_reg;
    logic [31:0] s3_v1_reg, s3_m2_reg;
    logic [31:0] s4_fine_reg;
    logic [31:0] s5_tm_reg, s5_pv1_reg, s5_hx_reg;
    logic [31:0] temp_reg [6:13];
    logic [31:0] s6_q2_reg, s6_mp5_reg, s6_mp2_reg, s6_hx5_reg, s6_hx6_reg, s6_hx3_reg;
    logic [31:0] s7_v2a_reg, s7_m3_reg, s7_ha_reg, s7_hb1_reg, s7_mp5_reg, s7_mp2_reg;
    logic [31:0] s8_v2_reg, s8_v1b_reg, s8_hb2_reg, s8_ha_reg;
    logic [31:0] s9_pc_reg, s9_pn_reg, s9_hb_reg, s9_ha_reg;
    logic [31:0] s10_den_reg, s10_pr_reg, s10_hx_reg;
    logic [31:0] s11_num_reg, s11_den_reg, s11_hsq_reg, s11_hx_reg;
    logic        s11_halve_reg;
    logic [31:0] s12_num_reg, s12_den_reg, s12_hsq2_reg, s12_hx_reg;
    logic        s12_halve_reg;
    logic [31:0] s13_num_reg, s13_den_reg;
    logic [16:0] s13_hum_reg;
    logic        s13_halve_reg;

    logic [31:0] q_c, hf_c, hcl_c;
    assign q_c  = asr(s5_pv1_reg, 2);
    assign hf_c = s12_hx_reg - asr(s12_hsq2_reg, 4);
    always_comb
    begin
        hcl_c = hf_c;
        if ($signed(hf_c) < 0)
            hcl_c = 32'd0;
        if ($signed(hf_c) > $signed(H_MAX))
            hcl_c = H_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a1_reg  <= (at >> 3) - (t1 << 1);
            s1_d_reg   <= (at >> 4) - t1;
            ap_reg[1]  <= ap_in;
            ah_reg[1]  <= ah_in;
            for (int i = 2; i <= 8; i++)
                ap_reg[i] <= ap_reg[i-1];
            for (int i = 2; i <= 6; i++)
                ah_reg[i] <= ah_reg[i-1];

            s2_m1_reg  <= s1_a1_reg * t2;
            s2_dd_reg  <= s1_d_reg * s1_d_reg;

            s3_v1_reg  <= asr(s2_m1_reg, 11);
            s3_m2_reg  <= asr(s2_dd_reg, 12) * t3;

            s4_fine_reg <= s3_v1_reg + asr(s3_m2_reg, 14);

            s5_tm_reg  <= (s4_fine_reg << 2) + s4_fine_reg + 32'd128;
            s5_pv1_reg <= asr(s4_fine_reg, 1) - P_OFFSET;
            s5_hx_reg  <= s4_fine_reg - H_OFFSET;

            temp_reg[6] <= asr(s5_tm_reg, 8);
            for (int i = 7; i <= 13; i++)
                temp_reg[i] <= temp_reg[i-1];
            s6_q2_reg  <= q_c * q_c;
            s6_mp5_reg <= s5_pv1_reg * p5;
            s6_mp2_reg <= p2 * s5_pv1_reg;
            s6_hx5_reg <= h5 * s5_hx_reg;
            s6_hx6_reg <= s5_hx_reg * h6;
            s6_hx3_reg <= s5_hx_reg * h3;

            s7_v2a_reg <= asr(s6_q2_reg, 11) * p6;
            s7_m3_reg  <= p3 * asr(s6_q2_reg, 13);
            s7_ha_reg  <= asr(((ah_reg[6] << 14) - (h4 << 20) - s6_hx5_reg) + H_ROUND_A, 15);
            s7_hb1_reg <= asr(s6_hx6_reg, 10) * (asr(s6_hx3_reg, 11) + P_HALF);
            s7_mp5_reg <= s6_mp5_reg;
            s7_mp2_reg <= s6_mp2_reg;

            s8_v2_reg  <= asr(s7_v2a_reg + (s7_mp5_reg << 1), 2) + (p4 << 16);
            s8_v1b_reg <= asr(asr(s7_m3_reg, 3) + asr(s7_mp2_reg, 1), 18);
            s8_hb2_reg <= (asr(s7_hb1_reg, 10) + H_BIAS) * h2 + H_ROUND_B;
            s8_ha_reg  <= s7_ha_reg;

            s9_pc_reg  <= (P_HALF + s8_v1b_reg) * p1;
            s9_pn_reg  <= (P_BASE - ap_reg[8]) - asr(s8_v2_reg, 12);
            s9_hb_reg  <= asr(s8_hb2_reg, 14);
            s9_ha_reg  <= s8_ha_reg;

            s10_den_reg <= asr(s9_pc_reg, 15);
            s10_pr_reg  <= s9_pn_reg * P_SCALE;
            s10_hx_reg  <= s9_ha_reg * s9_hb_reg;

            // a numerator with the top bit set divides first, doubles after
            s11_halve_reg <= s10_pr_reg[31];
            s11_num_reg   <= s10_pr_reg[31] ? s10_pr_reg : (s10_pr_reg << 1);
            s11_den_reg   <= s10_den_reg;
            s11_hsq_reg   <= asr(s10_hx_reg, 15) * asr(s10_hx_reg, 15);
            s11_hx_reg    <= s10_hx_reg;

            s12_halve_reg <= s11_halve_reg;
            s12_num_reg   <= s11_num_reg;
            s12_den_reg   <= s11_den_reg;
            s12_hsq2_reg  <= asr(s11_hsq_reg, 7) * h1;
            s12_hx_reg    <= s11_hx_reg;

            s13_halve_reg <= s12_halve_reg;
            s13_num_reg   <= s12_num_reg;
            s13_den_reg   <= s12_den_reg;
            s13_hum_reg   <= hcl_c[28:12];
        end
    end

    side_t       div_side_in, div_side_out;
    logic        div_vld;
    logic [31:0] div_quo;

    assign div_side_in.temp  = temp_reg[13];
    assign div_side_in.hum   = s13_hum_reg;
    assign div_side_in.halve = s13_halve_reg;
    assign div_side_in.zero  = (s13_den_reg == 32'd0);

    stc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (vld_reg[12]),
        .num      (s13_num_reg),
        .den      (s13_den_reg),
        .in_side  (div_side_in),
        .out_vld  (div_vld),
        .quo      (div_quo),
        .out_side (div_side_out)
    );

    // pressure refinement after the divide
    logic [2:0]  post_vld_reg;
    side_t       d1_side_reg, d2_side_reg, d3_side_reg;
    logic [31:0] d1_pres_reg, d2_pres_reg, d3_pres_reg;
    logic [31:0] d2_sq_reg, d2_bm_reg, d3_am_reg, d3_b_reg;
    logic [31:0] s3c;
    logic [31:0] pfin_c;

    assign s3c    = d1_pres_reg >> 3;
    assign pfin_c = d3_side_reg.zero ? 32'd0
                  : d3_pres_reg + asr(asr(d3_am_reg, 12) + d3_b_reg + p7, 4);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_side_reg <= div_side_out;
            d1_pres_reg <= div_side_out.halve ? (div_quo << 1) : div_quo;

            d2_side_reg <= d1_side_reg;
            d2_pres_reg <= d1_pres_reg;
            d2_sq_reg   <= s3c * s3c;
            d2_bm_reg   <= (d1_pres_reg >> 2) * p8;

            d3_side_reg <= d2_side_reg;
            d3_pres_reg <= d2_pres_reg;
            d3_am_reg   <= p9 * (d2_sq_reg >> 13);
            d3_b_reg    <= asr(d2_bm_reg, 13);

            out_reg.temperature_centi <= d3_side_reg.temp;
            out_reg.pressure_pascal   <= pfin_c;
            out_reg.humidity_fixed    <= d3_side_reg.hum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            post_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg      <= {vld_reg[11:0], head_valid};
            post_vld_reg <= {post_vld_reg[1:0], div_vld};
            out_vld_reg  <= post_vld_reg[2];
        end
    end

endmodule

// ----- rtl/sensor_trim_compensation.sv -----
// ----------------------------------------------------------------------------
// sensor_trim_compensation
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid / in_stall    in_data   (in_item_t)
//  out       out_valid / out_stall  out_data  (out_item_t)
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per cycle sustained while the output is not stalled; items pass
//  the queue, 13 arithmetic, 32 divider and 4 pressure refinement stages.
//  Reset clears queue and pipeline valid bits and zeroes the trim registers.
//  An output stall with out_valid high freezes the pipeline; the two-entry
//  input queue keeps accepting until full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module sensor_trim_compensation
    import stc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    trim_t    trim_reg;
    logic     head_valid;
    in_item_t head_data;
    logic     pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trim_reg <= '0;
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEMPERATURE: trim_reg.temperature <= cfg_data[47:0];
                CFG_PRESSURE_A:  trim_reg.pressure_a  <= cfg_data[47:0];
                CFG_PRESSURE_B:  trim_reg.pressure_b  <= cfg_data[47:0];
                CFG_PRESSURE_C:  trim_reg.pressure_c  <= cfg_data[47:0];
                CFG_HUMIDITY:    trim_reg.humidity    <= cfg_data;
                default: ;
            endcase
        end
    end

    stc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop)
    );

    stc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .trim       (trim_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ----- rtl/stc_checker.sv -----
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks for sensor trim compensation, bound to the top level.
// ----------------------------------------------------------------------------
module stc_checker
    import stc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out_data changed while stalled");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.humidity_fixed <= 17'd102400)
        else $error("humidity above full scale");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({out_valid, in_stall}))
        else $error("handshake output unknown");

endmodule

bind sensor_trim_compensation stc_checker u_stc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
